// File: src/mmfs_pkg.sv
// Package for the min-max feature scaler: sizes, command and status codes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package mmfs_pkg;

  localparam int NUM_FEATURES = 16;
  localparam int FRAC_BITS    = 16;

  localparam int DATA_W = 32;
  localparam int FEAT_W = 4;
  // Slots that the feature field can actually reach.
  localparam int SLOTS  = (NUM_FEATURES < 2 ** FEAT_W) ? NUM_FEATURES : 2 ** FEAT_W;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // Dividend magnitude: |x - min| shifted up by the fraction bits.
  localparam int NUM_W  = DATA_W + FRAC_BITS;
  localparam int STEP_W = $clog2(NUM_W);
  localparam int PROD_W = 2 * DATA_W;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);
  localparam logic [DATA_W-1:0] POS_MAX   = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_MIN   = {1'b1, {(DATA_W - 1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_OBSERVE = 2'd1,
    CMD_SCALE   = 2'd2,
    CMD_UNSCALE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_RANGE = 2'd1,
    ST_UNSEEN     = 2'd2,
    ST_SAT        = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DIV,
    S_MUL,
    S_FIN,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RES_OK,
    RES_ZERO_RANGE,
    RES_UNSEEN,
    RES_QUOT,
    RES_PROD
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     clear_seen;
    logic     observe_wr;
    logic     op_load;
    logic     div_step;
    logic     mul_step;
    logic     set_result;
    res_sel_t res_sel;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic slot_valid;
    logic slot_ok;
    logic zero_range;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: src/mmfs_if.sv
// Handshake channels of the min-max feature scaler: input items and result items.
// Depends on mmfs_pkg.
`default_nettype none

interface mmfs_in_if import mmfs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [FEAT_W-1:0]        feature;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, cmd, feature, value, input ready);
  modport sink   (input valid, cmd, feature, value, output ready);
endinterface

interface mmfs_out_if import mmfs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result;
  logic [1:0]               status;

  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

`default_nettype wire

// File: src/min_max_feature_scaler_top.sv
// Top level of the min-max feature scaler: controller, datapath and channel hookup.
// Depends on mmfs_pkg, mmfs_if, mmfs_ram, mmfs_dp and mmfs_ctrl.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+----------------------------------------
//   in_ch   | in  | valid / ready      | cmd[1:0], feature[3:0], value[31:0] s
//   out_ch  | out | valid / ready      | result[31:0] s, status[1:0]
//
// One item is worked at a time; ready is low in reset. Clear and observe pass from acceptance
// through read, evaluate and done; unscale adds one registered 33x33 multiply and a finish
// state; scale runs the restoring divider, which retires one quotient bit per cycle over the
// 48-bit dividend, and gives its result in Q16.16. rst_n is synchronous, active low; it
// clears the seen flags and the control state, the min/max RAMs keep their contents.
// A stalled result sits in the output register while the next item is worked; only the load waits.
`default_nettype none

module min_max_feature_scaler_top import mmfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mmfs_in_if.sink    in_ch,
  mmfs_out_if.source out_ch
);

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;
  logic     in_ready;

  // Ready comes from the controller alone: high only while it waits for an item.
  assign in_ch.ready = in_ready;

  // Sequencer: steps each item through read, evaluate, divide/multiply and load.
  mmfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat_i   (dp_stat),
    .cmd_o    (ctl_cmd)
  );

  // Datapath: holds the item, the min/max table, the seen flags and the
  // output register that drives the result channel.
  mmfs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (ctl_cmd),
    .stat_o     (dp_stat),
    .in_cmd     (in_ch.cmd),
    .in_feature (in_ch.feature),
    .in_value   (in_ch.value),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// File: src/mmfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mmfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/mmfs_dp.sv
// Datapath of the min-max feature scaler: item latch, min/max RAMs, seen flags,
// restoring divider, multiplier, result clamp and output register.
// Depends on mmfs_pkg, mmfs_if and mmfs_ram.
`default_nettype none

module mmfs_dp import mmfs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_cmd_t                 cmd_i,
  output dp_stat_t                 stat_o,
  input  logic [1:0]               in_cmd,
  input  logic [FEAT_W-1:0]        in_feature,
  input  logic signed [DATA_W-1:0] in_value,
  mmfs_out_if.source               out_ch
);

  cmd_t                     cmd_r;
  logic [FEAT_W-1:0]        feat_r;
  logic signed [DATA_W-1:0] x_r;
  logic                     seen_r [SLOTS];
  logic signed [DATA_W-1:0] lo_r;
  logic [DATA_W-1:0]        den_r;
  logic                     neg_r;
  logic [NUM_W-1:0]         quo_r;
  logic [DATA_W-1:0]        rem_r;
  logic [PROD_W-1:0]        prod_r;
  logic signed [DATA_W-1:0] res_r;
  status_t                  res_st_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_result_r;
  status_t                  out_status_r;

  logic [SLOT_W-1:0]        slot;
  logic                     slot_valid;
  logic                     seen_cur;
  logic [DATA_W-1:0]        min_raw;
  logic [DATA_W-1:0]        max_raw;
  logic signed [DATA_W-1:0] min_rd;
  logic signed [DATA_W-1:0] max_rd;
  logic signed [DATA_W:0]   range_w;
  logic signed [DATA_W:0]   diff_w;
  logic signed [DATA_W:0]   diff_neg_w;
  logic [DATA_W-1:0]        mag_w;
  logic signed [DATA_W-1:0] new_min;
  logic signed [DATA_W-1:0] new_max;
  logic [DATA_W:0]          trial;
  logic [DATA_W:0]          trial_sub;
  logic                     fits;
  logic signed [PROD_W:0]   prod_w;
  logic signed [PROD_W-1:0] sh_w;
  logic signed [PROD_W:0]   sum_w;
  logic                     sat_mul;
  logic [DATA_W-1:0]        quo_neg;
  logic signed [DATA_W-1:0] res_nxt;
  status_t                  res_st_nxt;

  assign slot       = feat_r[SLOT_W-1:0];
  assign slot_valid = 32'(feat_r) < NUM_FEATURES;
  assign seen_cur   = slot_valid && seen_r[slot];

  mmfs_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_min_ram (
    .clk   (clk),
    .we    (cmd_i.observe_wr),
    .waddr (slot),
    .wdata (new_min),
    .raddr (slot),
    .rdata (min_raw)
  );

  mmfs_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_max_ram (
    .clk   (clk),
    .we    (cmd_i.observe_wr),
    .waddr (slot),
    .wdata (new_max),
    .raddr (slot),
    .rdata (max_raw)
  );

  assign min_rd = $signed(min_raw);
  assign max_rd = $signed(max_raw);

  // First sample after a clear sets both bounds.
  assign new_min = (!seen_cur || (x_r < min_rd)) ? x_r : min_rd;
  assign new_max = (!seen_cur || (x_r > max_rd)) ? x_r : max_rd;

  assign range_w    = {max_rd[DATA_W-1], max_rd} - {min_rd[DATA_W-1], min_rd};
  assign diff_w     = {x_r[DATA_W-1], x_r} - {min_rd[DATA_W-1], min_rd};
  assign diff_neg_w = -diff_w;
  assign mag_w      = diff_w[DATA_W] ? diff_neg_w[DATA_W-1:0] : diff_w[DATA_W-1:0];

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial     = {rem_r, quo_r[NUM_W-1]};
  assign fits      = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  assign prod_w = $signed({x_r[DATA_W-1], x_r}) * $signed({1'b0, den_r});

  // Floor shift of the product, then add min; saturate on overflow of 32 bits.
  assign sh_w    = $signed(prod_r) >>> FRAC_BITS;
  assign sum_w   = {sh_w[PROD_W-1], sh_w} +
                   {{(PROD_W - DATA_W + 1){lo_r[DATA_W-1]}}, lo_r};
  assign sat_mul = !(&sum_w[PROD_W:DATA_W-1]) && (|sum_w[PROD_W:DATA_W-1]);

  assign quo_neg = -quo_r[DATA_W-1:0];

  always_comb begin
    res_nxt    = '0;
    res_st_nxt = ST_OK;
    unique case (cmd_i.res_sel)
      RES_OK: begin
        res_st_nxt = ST_OK;
      end
      RES_ZERO_RANGE: begin
        res_st_nxt = ST_ZERO_RANGE;
      end
      RES_UNSEEN: begin
        res_st_nxt = ST_UNSEEN;
      end
      RES_QUOT: begin
        if (!neg_r && (quo_r > NUM_W'(POS_MAX))) begin
          res_nxt    = $signed(POS_MAX);
          res_st_nxt = ST_SAT;
        end else if (neg_r && (quo_r > NUM_W'(NEG_MIN))) begin
          res_nxt    = $signed(NEG_MIN);
          res_st_nxt = ST_SAT;
        end else begin
          res_nxt = neg_r ? $signed(quo_neg) : $signed(quo_r[DATA_W-1:0]);
        end
      end
      RES_PROD: begin
        if (sat_mul) begin
          res_nxt    = sum_w[PROD_W] ? $signed(NEG_MIN) : $signed(POS_MAX);
          res_st_nxt = ST_SAT;
        end else begin
          res_nxt = sum_w[DATA_W-1:0];
        end
      end
      default: begin
        res_st_nxt = ST_OK;
      end
    endcase
  end

  // Control state: seen flags and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        seen_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.clear_seen) begin
        for (int i = 0; i < SLOTS; i++) begin
          seen_r[i] <= 1'b0;
        end
      end else if (cmd_i.observe_wr) begin
        seen_r[slot] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      cmd_r  <= cmd_t'(in_cmd);
      feat_r <= in_feature;
      x_r    <= in_value;
    end
    if (cmd_i.op_load) begin
      lo_r  <= min_rd;
      den_r <= range_w[DATA_W-1:0];
      neg_r <= diff_w[DATA_W];
      quo_r <= NUM_W'(mag_w) << FRAC_BITS;
      rem_r <= '0;
    end else if (cmd_i.div_step) begin
      rem_r <= fits ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
    if (cmd_i.mul_step) begin
      prod_r <= prod_w[PROD_W-1:0];
    end
    if (cmd_i.set_result) begin
      res_r    <= res_nxt;
      res_st_r <= res_st_nxt;
    end
    if (cmd_i.out_load) begin
      out_result_r <= res_r;
      out_status_r <= res_st_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = out_result_r;
  assign out_ch.status = out_status_r;

  assign stat_o.cmd        = cmd_r;
  assign stat_o.slot_valid = slot_valid;
  assign stat_o.slot_ok    = seen_cur;
  assign stat_o.zero_range = range_w[DATA_W] || (range_w == '0);
  assign stat_o.out_free   = !out_valid_r || out_ch.ready;

`ifndef NO_ASSERTIONS
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd_i.div_step) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  a_observe_sets_seen: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.observe_wr |=> seen_r[$past(slot)])
    else $error("observed slot not marked seen");
`endif

endmodule

`default_nettype wire

// File: src/mmfs_ctrl.sv
// Controller of the min-max feature scaler: sequences read, evaluate, divide or
// multiply, result and output load for one item at a time.
// Depends on mmfs_pkg.
`default_nettype none

module mmfs_ctrl import mmfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat_i,
  output ctl_cmd_t cmd_o
);

  state_t            state_r;
  state_t            state_nxt;
  logic [STEP_W-1:0] cnt_r;
  logic [STEP_W-1:0] cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd_o     = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd_o.capture = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.set_result = 1'b1;
        cmd_o.res_sel    = RES_OK;
        state_nxt        = S_DONE;
        unique case (stat_i.cmd)
          CMD_CLEAR: begin
            cmd_o.clear_seen = 1'b1;
          end
          CMD_OBSERVE: begin
            if (stat_i.slot_valid) begin
              cmd_o.observe_wr = 1'b1;
            end else begin
              cmd_o.res_sel = RES_UNSEEN;
            end
          end
          CMD_SCALE, CMD_UNSCALE: begin
            priority if (!stat_i.slot_ok) begin
              cmd_o.res_sel = RES_UNSEEN;
            end else if (stat_i.zero_range) begin
              cmd_o.res_sel = RES_ZERO_RANGE;
            end else begin
              cmd_o.set_result = 1'b0;
              cmd_o.op_load    = 1'b1;
              cnt_nxt          = '0;
              state_nxt        = (stat_i.cmd == CMD_SCALE) ? S_DIV : S_MUL;
            end
          end
          default: begin
            cmd_o.res_sel = RES_OK;
          end
        endcase
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_r == STEP_LAST) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        cmd_o.set_result = 1'b1;
        cmd_o.res_sel    = (stat_i.cmd == CMD_SCALE) ? RES_QUOT : RES_PROD;
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("output register loaded while occupied");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == STEP_LAST) |=> (state_r == S_FIN))
    else $error("divider did not finish after last step");

  a_scale_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && stat_i.cmd == CMD_SCALE) |-> ($past(state_r) == S_DIV))
    else $error("scale result taken without a full division");
`endif

endmodule

`default_nettype wire
